### hw/rtl/sorted_expiry_timer_queue_core_defines.svh
// Assertion macros used by the timer queue core.
`ifndef SORTED_EXPIRY_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SETQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("timer queue check failed");
`define SETQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");
`else
`define SETQ_ASSERT(label, clk, rst_n, prop)
`define SETQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/setq_pkg.sv
// Shared constants and codes of the sorted expiry timer queue.
package setq_pkg;
  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned HANDLE_BITS = 10;
  localparam int unsigned TIME_BITS   = 32;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
endpackage

### hw/rtl/setq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module setq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/sorted_expiry_timer_queue_core.sv
// Top level of the sorted expiry timer queue: control sequencer around the entry RAM.
// Usage:
// The slave stream carries one command per beat: tuser holds the opcode (add,
// delete, tick), tdata holds handle, expiry time and current time. The master
// stream returns result beats: tdata is the expired handle, tuser holds the
// expired flag and the status, tlast marks the final beat of a command.
// Entries sit in one RAM used as a ring; a tick moves the ring head past the expired entries.
// Handshake: one command at a time; s_axis_tready is high only while idle, and the
// block returns to idle when the final beat of a command is loaded.
// An add walks down from the top of the table and shifts each later entry up by
// one; a delete walks over all stored entries; a tick walks over the expired
// entries up to the first unexpired one and emits a beat for each of them. A full
// add and an unused opcode give their beat without a RAM pass. Each entry is
// read, compared and then written back or emitted.
// Reset empties the table at once; no clearing pass is needed.
// A result waits in an output register; while the receiver stalls, the
// sequencer holds before each further beat and loses no data.
`include "sorted_expiry_timer_queue_core_defines.svh"
module sorted_expiry_timer_queue_core #(
  parameter int unsigned CAPACITY    = setq_pkg::CAPACITY,
  parameter int unsigned HANDLE_BITS = setq_pkg::HANDLE_BITS,
  parameter int unsigned TIME_BITS   = setq_pkg::TIME_BITS,
  localparam int unsigned IN_W  = ((HANDLE_BITS + 2 * TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((HANDLE_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // timer_handle, expire_time, now_time
  input  logic [1:0]       s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // expired_handle
  output logic [2:0]       m_axis_tuser,  // expired_valid, status
  output logic             m_axis_tlast
);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = HANDLE_BITS + TIME_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIN, ST_ADD_RD, ST_ADD_CMP, ST_DEL_RD, ST_DEL_CMP, ST_TICK_RD, ST_TICK_CMP
  } state_e;

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, idx_q, idx_d, wr_q, wr_d;
  logic                   found_q, found_d, pend_q, pend_d;
  logic [HANDLE_BITS-1:0] pend_hnd_q, pend_hnd_d, hnd_q, hnd_d;
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [1:0]             fin_stat_q, fin_stat_d;
  logic                   out_valid_q;
  logic [HANDLE_BITS-1:0] out_hnd_q;
  logic                   out_ev_q, out_last_q;
  logic [1:0]             out_stat_q;

  logic                   emit, e_ev, e_last;
  logic [HANDLE_BITS-1:0] e_hnd;
  logic [1:0]             e_stat;
  logic                   out_free;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [ENT_W-1:0]       ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0]   rd_time;
  logic [HANDLE_BITS-1:0] rd_hnd;
  logic [1:0]             in_op;

  // Logical position to RAM address on the ring.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  setq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_time  = ram_rdata[TIME_BITS-1:0];
  assign rd_hnd   = ram_rdata[TIME_BITS +: HANDLE_BITS];
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_op    = s_axis_tuser;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    found_d    = found_q;
    pend_d     = pend_q;
    pend_hnd_d = pend_hnd_q;
    hnd_d      = hnd_q;
    time_d     = time_q;
    fin_stat_d = fin_stat_q;
    emit       = 1'b0;
    e_hnd      = '0;
    e_ev       = 1'b0;
    e_stat     = setq_pkg::STAT_OK;
    e_last     = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = phys(head_q, idx_q);
    ram_wdata  = {hnd_q, time_q};
    ram_raddr  = phys(head_q, idx_q);

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          hnd_d = s_axis_tdata[HANDLE_BITS-1:0];
          idx_d = '0;
          wr_d  = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          fin_stat_d = setq_pkg::STAT_OK;
          unique case (in_op)
            setq_pkg::OP_ADD: begin
              time_d = s_axis_tdata[HANDLE_BITS +: TIME_BITS];
              idx_d  = cnt_q;
              if (cnt_q == CNT_W'(CAPACITY)) begin
                fin_stat_d = setq_pkg::STAT_FULL;
                state_d    = ST_FIN;
              end else begin
                state_d = ST_ADD_RD;
              end
            end
            setq_pkg::OP_DEL:  state_d = ST_DEL_RD;
            setq_pkg::OP_TICK: begin
              time_d  = s_axis_tdata[HANDLE_BITS+TIME_BITS +: TIME_BITS];
              state_d = ST_TICK_RD;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit    = 1'b1;
          e_stat  = fin_stat_q;
          state_d = ST_IDLE;
        end
      end
      ST_ADD_RD: begin
        ram_raddr = phys(head_q, idx_q - CNT_W'(1));
        if (out_free) begin
          if (idx_q == '0) begin
            ram_we  = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
            emit    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ADD_CMP;
          end
        end
      end
      ST_ADD_CMP: begin
        ram_we = 1'b1;
        if (rd_time > time_q) begin
          // Shift the later entry up by one and keep walking down.
          ram_wdata = ram_rdata;
          idx_d     = idx_q - CNT_W'(1);
          state_d   = ST_ADD_RD;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DEL_RD: begin
        if (out_free) begin
          if (idx_q == cnt_q) begin
            cnt_d   = wr_q;
            emit    = 1'b1;
            e_stat  = found_q ? setq_pkg::STAT_OK : setq_pkg::STAT_NOT_FOUND;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DEL_CMP;
          end
        end
      end
      ST_DEL_CMP: begin
        ram_waddr = phys(head_q, wr_q);
        ram_wdata = ram_rdata;
        if (rd_hnd == hnd_q) begin
          found_d = 1'b1;
        end else begin
          ram_we = 1'b1;
          wr_d   = wr_q + CNT_W'(1);
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = ST_DEL_RD;
      end
      ST_TICK_RD: begin
        if (out_free) begin
          if (idx_q == cnt_q) begin
            emit    = 1'b1;
            e_hnd   = pend_q ? pend_hnd_q : '0;
            e_ev    = pend_q;
            head_d  = phys(head_q, idx_q);
            cnt_d   = cnt_q - idx_q;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_TICK_CMP;
          end
        end
      end
      ST_TICK_CMP: begin
        // One expired entry is held back until the next one shows whether it is last.
        if (rd_time <= time_q) begin
          emit       = pend_q;
          e_hnd      = pend_hnd_q;
          e_ev       = 1'b1;
          e_last     = 1'b0;
          pend_d     = 1'b1;
          pend_hnd_d = rd_hnd;
          idx_d      = idx_q + CNT_W'(1);
          state_d    = ST_TICK_RD;
        end else begin
          emit    = 1'b1;
          e_hnd   = pend_q ? pend_hnd_q : '0;
          e_ev    = pend_q;
          head_d  = phys(head_q, idx_q);
          cnt_d   = cnt_q - idx_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      wr_q        <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      fin_stat_q  <= setq_pkg::STAT_OK;
      pend_hnd_q  <= '0;
      hnd_q       <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      out_hnd_q   <= '0;
      out_ev_q    <= 1'b0;
      out_stat_q  <= setq_pkg::STAT_OK;
      out_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      wr_q       <= wr_d;
      found_q    <= found_d;
      pend_q     <= pend_d;
      fin_stat_q <= fin_stat_d;
      pend_hnd_q <= pend_hnd_d;
      hnd_q      <= hnd_d;
      time_q     <= time_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        out_hnd_q   <= e_hnd;
        out_ev_q    <= e_ev;
        out_stat_q  <= e_stat;
        out_last_q  <= e_last;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_hnd_q);
  assign m_axis_tuser  = {out_stat_q, out_ev_q};
  assign m_axis_tlast  = out_last_q;

  `SETQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(CAPACITY))
  `SETQ_ASSERT(a_head_bound, clk_i, rst_ni, head_q <= IDX_W'(CAPACITY - 1))
  `SETQ_ASSERT_IMPL(a_slot_free, clk_i, rst_ni, state_q == ST_TICK_CMP || state_q == ST_ADD_CMP, !out_valid_q)
endmodule

### test/testbench.sv
// Self-checking testbench for the sorted expiry timer queue core.
`timescale 1ns / 100ps
module testbench;
  localparam int unsigned CAPACITY    = setq_pkg::CAPACITY;
  localparam int unsigned HANDLE_BITS = setq_pkg::HANDLE_BITS;
  localparam int unsigned TIME_BITS   = setq_pkg::TIME_BITS;
  localparam int unsigned IN_W  = ((HANDLE_BITS + 2 * TIME_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((HANDLE_BITS + 7) / 8) * 8;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] hnd;
    logic                   valid;
    logic [1:0]             status;
    logic                   last;
  } timer_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [2:0]       m_axis_tuser;
  logic             m_axis_tlast;

  // Predicted table contents, kept sorted by expiry time.
  logic [TIME_BITS-1:0]   model_expiry[$];
  logic [HANDLE_BITS-1:0] model_handle[$];
  timer_result_t          pending_results[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  long_hold_req = 1'b0;
  int  long_hold_count = 0;
  int  hold_cycles = 0;

  sorted_expiry_timer_queue_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic timer_result_t make_result(logic [HANDLE_BITS-1:0] hnd, logic valid,
                                                logic [1:0] status, logic last);
    timer_result_t r;
    r.hnd = hnd;
    r.valid = valid;
    r.status = status;
    r.last = last;
    return r;
  endfunction

  task automatic queue_result(timer_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Applies one command to the table copy and queues the results it causes.
  task automatic predict_command(setq_pkg::opcode_e op, logic [HANDLE_BITS-1:0] hnd,
                                 logic [TIME_BITS-1:0] when, logic [TIME_BITS-1:0] now);
    int pos;
    int n;
    bit found;
    case (op)
      setq_pkg::OP_ADD: begin
        if (model_expiry.size() >= CAPACITY) begin
          queue_result(make_result('0, 1'b0, setq_pkg::STAT_FULL, 1'b1));
        end else begin
          pos = model_expiry.size();
          while (pos > 0 && model_expiry[pos-1] > when) pos--;
          model_expiry.insert(pos, when);
          model_handle.insert(pos, hnd);
          queue_result(make_result('0, 1'b0, setq_pkg::STAT_OK, 1'b1));
        end
      end
      setq_pkg::OP_DEL: begin
        found = 1'b0;
        pos = 0;
        while (pos < model_handle.size()) begin
          if (model_handle[pos] == hnd) begin
            found = 1'b1;
            model_handle.delete(pos);
            model_expiry.delete(pos);
          end else begin
            pos++;
          end
        end
        queue_result(make_result('0, 1'b0,
                                 found ? setq_pkg::STAT_OK : setq_pkg::STAT_NOT_FOUND,
                                 1'b1));
      end
      setq_pkg::OP_TICK: begin
        n = 0;
        while (n < model_expiry.size() && model_expiry[n] <= now) n++;
        if (n == 0) begin
          queue_result(make_result('0, 1'b0, setq_pkg::STAT_OK, 1'b1));
        end
        for (int i = 0; i < n; i++) begin
          queue_result(make_result(model_handle[0], 1'b1, setq_pkg::STAT_OK,
                                   i == n - 1));
          model_handle.pop_front();
          model_expiry.pop_front();
        end
      end
      default: queue_result(make_result('0, 1'b0, setq_pkg::STAT_OK, 1'b1));
    endcase
  endtask

  // Sends one command beat after a random gap and predicts its results.
  // The beat stays offered after acceptance until the next call or a drain.
  task automatic send_command(setq_pkg::opcode_e op, logic [HANDLE_BITS-1:0] hnd,
                              logic [TIME_BITS-1:0] when, logic [TIME_BITS-1:0] now);
    int gap;
    logic [IN_W-1:0] beat;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    beat = '0;
    beat[HANDLE_BITS-1:0] = hnd;
    beat[HANDLE_BITS +: TIME_BITS] = when;
    beat[HANDLE_BITS + TIME_BITS +: TIME_BITS] = now;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= beat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_command(op, hnd, when, now);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: one long hold when requested, otherwise a random stall per beat.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && long_hold_count < LONG_HOLD_CYCLES) begin
      long_hold_count <= long_hold_count + 1;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      hold_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    timer_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result hnd=%0d tuser=%0h last=%0b", $time,
                 m_axis_tdata[HANDLE_BITS-1:0], m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[HANDLE_BITS-1:0] !== want.hnd) begin
          $display("%0t: handle expected %0d actual %0d", $time, want.hnd,
                   m_axis_tdata[HANDLE_BITS-1:0]);
          error_count++;
        end
        if (m_axis_tdata[OUT_W-1:HANDLE_BITS] !== '0) begin
          $display("%0t: tdata padding expected 0 actual %0h", $time, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== want.valid) begin
          $display("%0t: expired flag expected %0b actual %0b", $time, want.valid,
                   m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tuser[2:1] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tuser[2:1]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[sorted_expiry_timer_queue_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return {TIME_BITS{1'b1}} - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_command(setq_pkg::OP_TICK, '0, '0, '1);
    send_command(setq_pkg::OP_DEL, 10'd5, '0, '0);
    send_command(setq_pkg::OP_ADD, '1, '1, '0);
    send_command(setq_pkg::OP_ADD, '0, '0, '1);
    send_command(setq_pkg::OP_ADD, 10'd7, 32'd100, '0);
    send_command(setq_pkg::OP_ADD, 10'd8, 32'd100, '0);
    send_command(setq_pkg::OP_ADD, 10'd7, 32'd50, '0);
    send_command(setq_pkg::OP_NOP, '1, '1, '1);
    send_command(setq_pkg::OP_TICK, '0, '0, 32'd49);
    send_command(setq_pkg::OP_DEL, 10'd7, '0, '0);
    send_command(setq_pkg::OP_TICK, '1, '1, 32'd100);
    send_command(setq_pkg::OP_TICK, '0, '0, 32'hFFFF_FFFE);
    send_command(setq_pkg::OP_TICK, '0, '0, '1);
    send_command(setq_pkg::OP_DEL, '1, '0, '0);
  endtask

  // Fills the table past capacity with the receiver held off, then drains it.
  task automatic test_full_table();
    wait_drained();
    long_hold_req <= 1'b1;
    for (int i = 0; i < CAPACITY + 3; i++) begin
      send_command(setq_pkg::OP_ADD, HANDLE_BITS'($urandom), $urandom_range(0, 40), '0);
    end
    send_command(setq_pkg::OP_TICK, '0, '0, 32'd20);
    send_command(setq_pkg::OP_TICK, '0, '0, '1);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int op_pick;
    logic [HANDLE_BITS-1:0] hnd;
    for (int i = 0; i < count; i++) begin
      op_pick = $urandom_range(0, 19);
      hnd = (model_handle.size() != 0 && $urandom_range(0, 1))
            ? model_handle[$urandom_range(0, model_handle.size() - 1)]
            : HANDLE_BITS'($urandom);
      if (op_pick < 9) begin
        send_command(setq_pkg::OP_ADD, hnd, $urandom_range(0, 200), rand_time());
      end else if (op_pick < 13) begin
        send_command(setq_pkg::OP_DEL, hnd, rand_time(), rand_time());
      end else if (op_pick < 19) begin
        send_command(setq_pkg::OP_TICK, hnd, rand_time(),
                     $urandom_range(0, 1) ? $urandom_range(0, 220) : rand_time());
      end else begin
        send_command(setq_pkg::OP_NOP, HANDLE_BITS'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_random(90);
    wait_drained();
    test_random(80);
    wait_drained();
    if (error_count == 0) begin
      $display("[sorted_expiry_timer_queue_core] OK");
    end else begin
      $display("[sorted_expiry_timer_queue_core] ERROR");
    end
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/setq_pkg.sv
hw/rtl/setq_ram.sv
hw/rtl/sorted_expiry_timer_queue_core.sv
test/testbench.sv
